### hw/rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  // Fraction bits of every fixed-point value (coordinates Q4.28, z Q6.28).
  localparam int FRAC_BITS = 28;

  localparam int COORD_W = 32;
  localparam int ZVAL_W  = 34;
  localparam int OP_W    = 33;
  localparam int PROD_W  = 2 * OP_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ZVAL_W-1:0]  zval_t;
  typedef logic signed [OP_W-1:0]    op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // Operand pairs for the three multipliers of the shared unit.
  typedef struct packed {
    op_t a0;
    op_t b0;
    op_t a1;
    op_t b1;
    op_t a2;
    op_t b2;
  } mul_req_t;

  // Escape threshold 4.0 in Q.56, and the largest component magnitude 2.0
  // in Q6.28 that cannot by itself push |z|^2 past the threshold.
  localparam prod_t LIMIT = prod_t'(1) <<< (2 * FRAC_BITS + 2);
  localparam zval_t Z_MAX = zval_t'(1) <<< (FRAC_BITS + 1);

  localparam prod_t C_MAX = prod_t'(32'sh7FFF_FFFF);
  localparam prod_t C_MIN = -(prod_t'(1) <<< (COORD_W - 1));

  // Clamp an exact coordinate sum to the Q4.28 range.
  function automatic coord_t sat_coord(input prod_t v);
    coord_t r;
    if (v > C_MAX) begin
      r = coord_t'(C_MAX[COORD_W-1:0]);
    end else if (v < C_MIN) begin
      r = coord_t'(C_MIN[COORD_W-1:0]);
    end else begin
      r = coord_t'(v[COORD_W-1:0]);
    end
    return r;
  endfunction

  // True when one component alone already makes |z|^2 exceed 4.
  function automatic logic out_of_range(input zval_t v);
    return (v > Z_MAX) || (v < -Z_MAX);
  endfunction

endpackage

### hw/rtl/mbe_mul3.sv
`timescale 1ns / 1ps

// Three signed 33 x 33 multipliers with registered products.
module mbe_mul3 import mbe_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  mul_req_t req,
  output prod_t    p0,
  output prod_t    p1,
  output prod_t    p2
);

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= req.a0 * req.b0;
      p1 <= req.a1 * req.b1;
      p2 <= req.a2 * req.b2;
    end
  end

endmodule

### hw/rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time unit. A transaction is accepted when start is high
// and busy is low; column and row are sampled then. The block forms
// c = (x_origin + column*x_step, y_origin + row*y_step), saturated to signed
// Q4.28, and iterates z = z^2 + c from z = 0 with exact wide products. When
// the work is done, done is high for exactly one cycle with iteration_count
// and escaped; the receiver cannot stall, so it must take the result in that
// cycle. iteration_count is the 0-based iteration at which |z|^2 first went
// above 4 (escaped = 1), or max_iter-1 when it never did (escaped = 0); a
// max_iter of zero acts as one. A pixel first forms c in S_CMUL and S_CADD,
// then runs each iteration through S_SQ and S_UPD; the pace is set by the
// one bank of three multipliers, which alternates between a multiply cycle
// and an add, compare and update cycle. busy stays high from the accepting
// edge until done rises, and a new transaction can be accepted in the cycle
// done is high. Configuration registers are to be written with cfg_we,
// cfg_index and cfg_data only while the block is idle, a rule on the user
// that the block itself does not enforce; unknown indexes are ignored.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [INDEX_BITS-1:0] column,
  input  logic [INDEX_BITS-1:0] row,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  output logic                  busy,
  output logic                  done,
  output logic [15:0]           iteration_count,
  output logic                  escaped
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_CMUL = 3'd1;  // step times index
  localparam logic [2:0] S_CADD = 3'd2;  // origin plus product, saturate
  localparam logic [2:0] S_SQ   = 3'd3;  // square z in the shared unit
  localparam logic [2:0] S_UPD  = 3'd4;  // escape test and z update

  logic [2:0] state;

  // Configuration registers.
  logic [15:0] max_iter;
  coord_t      x_origin;
  coord_t      x_step;
  coord_t      y_origin;
  coord_t      y_step;

  // Per-pixel working registers.
  logic [INDEX_BITS-1:0] col_q;
  logic [INDEX_BITS-1:0] row_q;
  coord_t                cx;
  coord_t                cy;
  zval_t                 x;
  zval_t                 y;
  logic                  oor;
  logic [15:0]           k;

  logic [15:0] n_last;
  mul_req_t    req;
  logic        mul_en;
  prod_t       p0;
  prod_t       p1;
  prod_t       p2;
  prod_t       diff;
  prod_t       dbl;
  prod_t       x_sh;
  prod_t       y_sh;
  zval_t       x_upd;
  zval_t       y_upd;
  zval_t       cx_ext;
  zval_t       cy_ext;
  coord_t      cx_sat;
  coord_t      cy_sat;
  prod_t       mag;

  assign busy   = (state != S_IDLE);
  assign n_last = (max_iter == 16'd0) ? 16'd0 : (max_iter - 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= 16'd20;
      x_origin <= 32'shE000_0000;
      x_step   <= 32'sd393408;
      y_origin <= 32'shE800_0000;
      y_step   <= 32'sd393408;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER: max_iter <= cfg_data[15:0];
        REG_X_ORIGIN: x_origin <= coord_t'(cfg_data);
        REG_X_STEP:   x_step   <= coord_t'(cfg_data);
        REG_Y_ORIGIN: y_origin <= coord_t'(cfg_data);
        REG_Y_STEP:   y_step   <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // In the coordinate phase the unit forms step times index; in each
  // iteration it forms x*x, y*y and x*y. While z is in range its components
  // are at most 2.0, so the low 33 bits carry them exactly.
  always_comb begin
    req = '0;
    if (state == S_CMUL) begin
      req.a0 = op_t'(x_step);
      req.b0 = op_t'({{(OP_W-INDEX_BITS){1'b0}}, col_q});
      req.a1 = op_t'(y_step);
      req.b1 = op_t'({{(OP_W-INDEX_BITS){1'b0}}, row_q});
    end else begin
      req.a0 = op_t'(x[OP_W-1:0]);
      req.b0 = op_t'(x[OP_W-1:0]);
      req.a1 = op_t'(y[OP_W-1:0]);
      req.b1 = op_t'(y[OP_W-1:0]);
      req.a2 = op_t'(x[OP_W-1:0]);
      req.b2 = op_t'(y[OP_W-1:0]);
    end
  end

  assign mul_en = (state == S_CMUL) || ((state == S_SQ) && !oor);

  mbe_mul3 u_mul3 (
    .clk (clk),
    .en  (mul_en),
    .req (req),
    .p0  (p0),
    .p1  (p1),
    .p2  (p2)
  );

  // Coordinate sums are exact in the product width, then clamped.
  assign cx_sat = sat_coord(prod_t'(x_origin) + p0);
  assign cy_sat = sat_coord(prod_t'(y_origin) + p1);

  // The arithmetic right shift is a floor division by 2^28.
  assign diff   = p0 - p1;
  assign dbl    = p2 <<< 1;
  assign x_sh   = diff >>> FRAC_BITS;
  assign y_sh   = dbl >>> FRAC_BITS;
  assign cx_ext = zval_t'(cx);
  assign cy_ext = zval_t'(cy);
  assign x_upd  = zval_t'(x_sh[ZVAL_W-1:0]) + cx_ext;
  assign y_upd  = zval_t'(y_sh[ZVAL_W-1:0]) + cy_ext;
  assign mag    = p0 + p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          state <= S_CADD;
        end
        S_CADD: begin
          state <= S_SQ;
        end
        S_SQ: begin
          if (oor) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if ((mag > LIMIT) || (k == n_last)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_SQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          col_q <= column;
          row_q <= row;
        end
      end
      S_CADD: begin
        cx  <= cx_sat;
        cy  <= cy_sat;
        x   <= zval_t'(cx_sat);
        y   <= zval_t'(cy_sat);
        oor <= out_of_range(zval_t'(cx_sat)) || out_of_range(zval_t'(cy_sat));
        k   <= 16'd0;
      end
      S_SQ: begin
        if (oor) begin
          iteration_count <= k;
          escaped         <= 1'b1;
        end
      end
      S_UPD: begin
        if (mag > LIMIT) begin
          iteration_count <= k;
          escaped         <= 1'b1;
        end else if (k == n_last) begin
          iteration_count <= k;
          escaped         <= 1'b0;
        end else begin
          x   <= x_upd;
          y   <= y_upd;
          oor <= out_of_range(x_upd) || out_of_range(y_upd);
          k   <= k + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // A result only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // A pixel that did not escape reports the last iteration.
  a_no_escape_count: assert property (@(posedge clk) disable iff (rst)
    (done && !escaped) |-> (iteration_count == n_last))
    else $error("non-escaped count differs from max_iter-1");

  // The reported iteration never passes the limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (iteration_count <= n_last))
    else $error("iteration count beyond max_iter-1");

  // The iteration counter stays within the limit while squaring.
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (k <= n_last))
    else $error("iteration counter ran past the limit");

endmodule

### tb/mandelbrot_escape_time_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the escape-time unit,
// keeps its own copy of the view registers, predicts the result of every
// accepted pixel and compares each done strobe with the oldest prediction.
module mandelbrot_escape_time_checker import mbe_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [INDEX_BITS-1:0] column,
  input  logic [INDEX_BITS-1:0] row,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  done,
  input  logic [15:0]           iteration_count,
  input  logic                  escaped,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] column;
    logic [INDEX_BITS-1:0] row;
    logic [15:0]           count;
    logic                  escaped;
  } escape_t;

  localparam int    ONE_Q       = 1 << FRAC_BITS;
  localparam wide_t COORD_HI    = (wide_t'(1) <<< (COORD_W - 1)) - 1;
  localparam wide_t COORD_LO    = -(wide_t'(1) <<< (COORD_W - 1));
  localparam wide_t RADIUS_SQ   = wide_t'(1) <<< (2 * FRAC_BITS + 2);

  logic [15:0] iter_limit;
  coord_t      view_x0;
  coord_t      view_dx;
  coord_t      view_y0;
  coord_t      view_dy;
  escape_t     pending_escapes[$];
  escape_t     oldest;
  int          mismatches;

  // Exact origin + index*step, clamped to the Q4.28 range.
  function automatic coord_t pixel_coord(input coord_t origin, input coord_t step,
                                         input logic [INDEX_BITS-1:0] idx);
    wide_t exact;
    exact = wide_t'(origin) + wide_t'(step) * wide_t'({1'b0, idx});
    if (exact > COORD_HI) begin
      exact = COORD_HI;
    end else if (exact < COORD_LO) begin
      exact = COORD_LO;
    end
    return coord_t'(exact[COORD_W-1:0]);
  endfunction

  // Iterates z = z^2 + c from zero; the shifts floor toward minus infinity.
  function automatic escape_t escape_time(input logic [INDEX_BITS-1:0] col,
                                          input logic [INDEX_BITS-1:0] rw);
    wide_t       c_re;
    wide_t       c_im;
    wide_t       zx;
    wide_t       zy;
    wide_t       nx;
    wide_t       ny;
    int unsigned n;
    int unsigned k;
    escape_t     r;
    c_re = wide_t'(pixel_coord(view_x0, view_dx, col));
    c_im = wide_t'(pixel_coord(view_y0, view_dy, rw));
    n = (iter_limit == '0) ? 1 : int'(iter_limit);
    zx = '0;
    zy = '0;
    k = 0;
    r.column = col;
    r.row = rw;
    r.count = 16'(n - 1);
    r.escaped = 1'b0;
    while (k < n && !r.escaped) begin
      nx = ((zx * zx - zy * zy) >>> FRAC_BITS) + c_re;
      ny = (((zx * zy) <<< 1) >>> FRAC_BITS) + c_im;
      zx = nx;
      zy = ny;
      if (zx * zx + zy * zy > RADIUS_SQ) begin
        r.count = 16'(k);
        r.escaped = 1'b1;
      end
      k++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      iter_limit = 16'd20;
      view_x0 = coord_t'(-2 * ONE_Q);
      view_dx = coord_t'(393408);
      view_y0 = coord_t'(-(3 * ONE_Q / 2));
      view_dy = coord_t'(393408);
      pending_escapes.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (pending_escapes.size() == 0) begin
          mismatches++;
          $display("%0t: result with no pixel outstanding: expected none, got count %0d escaped %0b",
                   $time, iteration_count, escaped);
        end else begin
          oldest = pending_escapes.pop_front();
          if (iteration_count !== oldest.count) begin
            mismatches++;
            $display("%0t: pixel (%0d,%0d) iteration_count expected %0d, got %0d", $time,
                     oldest.column, oldest.row, oldest.count, iteration_count);
          end
          if (escaped !== oldest.escaped) begin
            mismatches++;
            $display("%0t: pixel (%0d,%0d) escaped expected %0b, got %0b", $time,
                     oldest.column, oldest.row, oldest.escaped, escaped);
          end
        end
      end
      if (start && !busy) begin
        pending_escapes.insert(pending_escapes.size(), escape_time(column, row));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ITER: iter_limit = cfg_data[15:0];
          REG_X_ORIGIN: view_x0 = coord_t'(cfg_data);
          REG_X_STEP:   view_dx = coord_t'(cfg_data);
          REG_Y_ORIGIN: view_y0 = coord_t'(cfg_data);
          REG_Y_STEP:   view_dy = coord_t'(cfg_data);
          default: ;
        endcase
      end
    end
    mismatch_count <= mismatches;
    pending_count <= pending_escapes.size();
  end

endmodule

### tb/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps

// Top of the escape-time unit bench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every pixel from
// its own copy of the view registers and counts the mismatches.
//
// The run is a sequence of views. Each view is written while the block is
// idle, then a batch of pixels is sent. A short directed part comes first:
// the reset view, saturating coordinates with a zero iteration limit, a
// pixel that escapes on its very last iteration, and one pixel at the
// largest limit that never escapes. The random part then cycles through
// views of the set at several iteration limits, views made of raw random
// register values, and a final deep view with a few pixels only.
module mandelbrot_escape_time_tb import mbe_pkg::*; ();

  localparam int INDEX_BITS   = 12;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int VIEW_PIXELS  = 112;
  localparam int RANDOM_VIEWS = 12;
  localparam int DEEP_PIXELS  = 6;
  localparam int GAP_CAP      = 200;

  localparam coord_t COORD_TOP    = coord_t'({1'b0, {(COORD_W - 1){1'b1}}});
  localparam coord_t COORD_BOTTOM = coord_t'({1'b1, {(COORD_W - 1){1'b0}}});

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic [INDEX_BITS-1:0] column;
  logic [INDEX_BITS-1:0] row;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_W-1:0]    cfg_data;
  logic                  busy;
  logic                  done;
  logic [15:0]           iteration_count;
  logic                  escaped;
  int                    fail_count;
  int                    outstanding;

  // Iteration limit of the current view; only used to size idle gaps.
  logic [15:0] gap_iter;
  // When set, pixels are offered back to back with no idle cycles.
  logic        burst;

  mandelbrot_escape_time #(
    .INDEX_BITS(INDEX_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .column(column),
    .row(row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .busy(busy),
    .done(done),
    .iteration_count(iteration_count),
    .escaped(escaped)
  );

  mandelbrot_escape_time_checker #(
    .INDEX_BITS(INDEX_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .column(column),
    .row(row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .iteration_count(iteration_count),
    .escaped(escaped),
    .mismatch_count(fail_count),
    .pending_count(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous bound on the slowest correct run: the one pixel at the largest
  // limit, every random pixel running to its limit, and every gap at its
  // longest all fit in well under a third of this.
  initial begin
    #(30_000_000);
    $display("Verification failed");
    $finish;
  end

  // Waits until every predicted result has come back and the block has
  // dropped busy. The pending count is registered, and the loop waits for a
  // clock edge before each check.
  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes all five registers and then one unused index. The unused write
  // comes last so that any aliasing onto a real register would corrupt the
  // view and show up as mismatches. The upper data bits of the limit write
  // are junk that the block has to drop.
  task automatic set_view(input logic [15:0] iter, input coord_t x0, input coord_t dx,
                          input coord_t y0, input coord_t dy);
    start <= 1'b0;
    wait_idle();
    write_reg(REG_MAX_ITER, {16'($urandom), iter});
    write_reg(REG_X_ORIGIN, x0);
    write_reg(REG_X_STEP, dx);
    write_reg(REG_Y_ORIGIN, y0);
    write_reg(REG_Y_STEP, dy);
    write_reg(CFG_IDX_W'($urandom_range(REG_Y_STEP + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    cfg_we <= 1'b0;
    gap_iter = iter;
  endtask

  task automatic set_iter_limit(input logic [15:0] iter);
    start <= 1'b0;
    wait_idle();
    write_reg(REG_MAX_ITER, {16'($urandom), iter});
    cfg_we <= 1'b0;
    gap_iter = iter;
  endtask

  // Offers one pixel and returns at the edge where the transaction is taken.
  // start is left high so that a following pixel with no gap goes straight in.
  task automatic send_pixel(input logic [INDEX_BITS-1:0] col, input logic [INDEX_BITS-1:0] rw);
    start <= 1'b1;
    column <= col;
    row <= rw;
    do @(posedge clk); while (busy);
  endtask

  // Mostly no gap or a short one; now and then a long one that can run past
  // the end of the pixel in flight, so that the idle stretch lands in any
  // phase of the block's iteration. The pixel ports carry noise meanwhile.
  task automatic idle_between_pixels();
    int unsigned pick;
    int unsigned span;
    int unsigned cycles;
    pick = $urandom_range(0, 99);
    span = 2 * ((gap_iter == '0) ? 1 : int'(gap_iter)) + 8;
    if (span > GAP_CAP) begin
      span = GAP_CAP;
    end
    if (burst || pick < 55) begin
      cycles = 0;
    end else if (pick < 90) begin
      cycles = $urandom_range(1, 3);
    end else begin
      cycles = $urandom_range(4, span);
    end
    if (cycles != 0) begin
      start <= 1'b0;
      column <= INDEX_BITS'($urandom);
      row <= INDEX_BITS'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic pixel(input logic [INDEX_BITS-1:0] col, input logic [INDEX_BITS-1:0] rw);
    send_pixel(col, rw);
    idle_between_pixels();
  endtask

  // Random view of the given kind. Kinds 0 to 2 frame part of the set at a
  // rising iteration limit, either the whole set or a small zoomed window,
  // with the occasional mirrored axis. Kind 3 takes raw register values, so
  // most points saturate and escape at once. Kind 4 is the deep view.
  task automatic random_view(input int kind);
    logic [15:0] iter;
    coord_t      x0;
    coord_t      dx;
    coord_t      y0;
    coord_t      dy;
    case (kind)
      0:       iter = 16'($urandom_range(0, 8));
      1:       iter = 16'($urandom_range(9, 64));
      2:       iter = 16'($urandom_range(65, 300));
      3:       iter = 16'($urandom_range(1, 40));
      default: iter = 16'($urandom_range(1000, 3000));
    endcase
    if (kind == 3) begin
      x0 = coord_t'($urandom);
      dx = coord_t'($urandom);
      y0 = coord_t'($urandom);
      dy = coord_t'($urandom);
    end else begin
      x0 = coord_t'(-(5 * ONE_Q / 2) + int'($urandom_range(0, 7 * ONE_Q / 2)));
      y0 = coord_t'(-(3 * ONE_Q / 2) + int'($urandom_range(0, 3 * ONE_Q)));
      dx = coord_t'($urandom_range(1, $urandom_range(0, 1) ? 7 * ONE_Q / 8192 : 2048));
      dy = coord_t'($urandom_range(1, $urandom_range(0, 1) ? 7 * ONE_Q / 8192 : 2048));
      if ($urandom_range(0, 3) == 0) begin
        dx = -dx;
      end
      if ($urandom_range(0, 3) == 0) begin
        dy = -dy;
      end
    end
    set_view(iter, x0, dx, y0, dy);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    column <= '0;
    row <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    gap_iter = 16'd20;
    burst = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset view: corners of the index range and a point inside the set.
    pixel(0, 0);
    pixel({INDEX_BITS{1'b1}}, {INDEX_BITS{1'b1}});
    pixel(0, {INDEX_BITS{1'b1}});
    pixel({INDEX_BITS{1'b1}}, 0);
    pixel(1365, 1024);

    // Zero iteration limit acts as one. Column zero gives the largest
    // coordinate exactly; any further column overflows and must saturate
    // high, and any row past zero must saturate low.
    set_view('0, COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM);
    pixel(0, 0);
    pixel({INDEX_BITS{1'b1}}, {INDEX_BITS{1'b1}});
    pixel(2048, 1);

    // c = 0.5 escapes at iteration four: with a limit of five that is the
    // last iteration, with a limit of four it never escapes.
    set_view(16'd5, coord_t'(ONE_Q / 2), '0, '0, '0);
    pixel(0, 0);
    set_iter_limit(16'd4);
    pixel(7, 9);

    // Largest limit with c = 0: the longest possible pixel, never escaping.
    set_view(16'hFFFF, '0, '0, '0, '0);
    pixel({INDEX_BITS{1'b1}}, {INDEX_BITS{1'b1}});

    // Random part. A quarter of the views run with no gaps at all.
    for (int v = 0; v <= RANDOM_VIEWS; v++) begin
      random_view((v == RANDOM_VIEWS) ? 4 : v % 4);
      burst = ($urandom_range(0, 3) == 0);
      repeat ((v == RANDOM_VIEWS) ? DEEP_PIXELS : VIEW_PIXELS) begin
        pixel(INDEX_BITS'($urandom), INDEX_BITS'($urandom));
      end
    end

    // Drain, then leave room for any stray result before the verdict.
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### mandelbrot_escape_time.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_mul3.sv
hw/rtl/mandelbrot_escape_time.sv
tb/mandelbrot_escape_time_checker.sv
tb/mandelbrot_escape_time_tb.sv
